// ----- rtl/gain_fader_bank_unit_macros.svh -----
`ifndef GAIN_FADER_BANK_UNIT_MACROS_SVH
`define GAIN_FADER_BANK_UNIT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define GFB_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define GFB_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ----- rtl/gfb_pkg.sv -----
`timescale 1ns / 1ps

package gfb_pkg;

   // Field widths
   localparam int GAIN_W = 16;
   localparam int TICK_W = 15;
   localparam int MASK_W = 64;
   localparam int IDX_W  = 6;
   localparam int TGT_W  = 17;
   localparam int LEN_W  = 16;
   localparam int OP_W   = 2;

   // Divider runs one quotient bit per cycle
   localparam int DIV_STEPS = TICK_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam int NUM_CHANNELS_DEF = 64;

   localparam logic [GAIN_W-1:0] UNITY_Q15 = 16'h8000;

   typedef enum logic [OP_W-1:0] {
      OP_ADVANCE = 2'd0,
      OP_SET     = 2'd1,
      OP_READ    = 2'd2,
      OP_RESTORE = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADV_RD,
      S_ADV_MUL,
      S_ADV_DIV,
      S_ADV_WR,
      S_SET,
      S_RD_ADDR,
      S_RD_DATA,
      S_RESULT
   } state_type;

endpackage

// ----- rtl/gain_fader_bank_unit.sv -----
`timescale 1ns / 1ps

// Channel  | Ports                      | Direction | Moves
// ---------+----------------------------+-----------+----------------------------------
// request  | req_valid / req_stall      | in        | operation, mask, target, length,
//          |                            |           | elapsed ticks, channel index
// response | rsp_valid / rsp_stall      | out       | gain_out, done_res
//
// Advance: each channel that is fading goes through read, multiply,
// 15 divider steps and write back; one that snaps goes through read and
// multiply only. Most of the work is in the shared restoring divider.
// Set: each channel in turn. Read: address, then data. Restore all: clears valid bits.
// Reset clears the valid bits, so every channel reads as unity with no fade.
// A finished word waits in the response register; the next request is
// taken while it is stalled there.

module gain_fader_bank_unit
   import gfb_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [MASK_W-1:0]        req_channel_mask,
   input  logic signed [TGT_W-1:0]  req_target_gain,
   input  logic signed [LEN_W-1:0]  req_fade_length,
   input  logic [TICK_W-1:0]        req_elapsed_ticks,
   input  logic [IDX_W-1:0]         req_channel_index,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [GAIN_W-1:0]        rsp_gain_out,
   output logic                     rsp_done_res
);

   `include "gain_fader_bank_unit_macros.svh"

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Channel store
   logic [GAIN_W-1:0] gain_mem [NUM_CHANNELS];
   logic [GAIN_W-1:0] targ_mem [NUM_CHANNELS];
   logic [TICK_W-1:0] tick_mem [NUM_CHANNELS];

   state_type                state_ff, state_in;
   logic [CH_W-1:0]          ch_ff, ch_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [NUM_CHANNELS-1:0]  mask_ff, mask_in;
   logic [GAIN_W-1:0]        targ_ff, targ_in;
   logic [TICK_W-1:0]        len_ff, len_in;
   logic [TICK_W-1:0]        elapsed_ff, elapsed_in;
   logic [CH_W-1:0]          idx_ff, idx_in;
   logic                     idx_ok_ff, idx_ok_in;
   logic [NUM_CHANNELS-1:0]  gain_vld_ff, gain_vld_in;
   logic [NUM_CHANNELS-1:0]  lvl_vld_ff, lvl_vld_in;
   logic [GAIN_W-1:0]        cur_ff, cur_in;
   logic [TICK_W-1:0]        left_ff, left_in;
   logic                     neg_ff, neg_in;
   logic [TICK_W-1:0]        rem_ff, rem_in;
   logic [TICK_W-1:0]        dvd_ff, dvd_in;
   logic [TICK_W-1:0]        quo_ff, quo_in;
   logic [GAIN_W-1:0]        res_gain_ff, res_gain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [GAIN_W-1:0]        rsp_gain_ff, rsp_gain_in;
   logic [GAIN_W-1:0]        gain_rd_ff, targ_rd_ff;
   logic [TICK_W-1:0]        tick_rd_ff;

   // Control from the output decoder
   logic              accept;
   logic              clr_all;
   logic              gain_we, tick_we, targ_we;
   logic [GAIN_W-1:0] gain_wd;
   logic [TICK_W-1:0] tick_wd;
   logic [CH_W-1:0]   rd_addr;
   logic              ld_rsp;

   // Datapath terms
   logic              last_ch;
   logic [GAIN_W-1:0] cur_gain, cur_targ;
   logic [TICK_W-1:0] cur_tick;
   logic              run;
   logic              diff_neg;
   logic [GAIN_W-1:0] diff_mag;
   logic [30:0]       prod;
   logic [TICK_W:0]   div_part;
   logic [TICK_W:0]   div_trial;
   logic              div_take;
   logic [GAIN_W-1:0] wr_gain;
   logic [TICK_W-1:0] wr_tick;
   logic [GAIN_W-1:0] tgt_clamp;
   logic [TICK_W-1:0] len_clamp;
   op_type            req_op;

   assign req_op  = op_type'(req_operation);
   assign last_ch = (ch_ff == CH_W'(NUM_CHANNELS - 1));

   // Clamp the request target to 0..unity and the length to non-negative
   always_comb begin
      if (req_target_gain[TGT_W-1]) begin
         tgt_clamp = '0;
      end else if (req_target_gain[GAIN_W-1:0] > UNITY_Q15) begin
         tgt_clamp = UNITY_Q15;
      end else begin
         tgt_clamp = req_target_gain[GAIN_W-1:0];
      end
      len_clamp = req_fade_length[LEN_W-1] ? '0 : req_fade_length[TICK_W-1:0];
   end

   // Channel values as read, with never-written entries at their reset values
   assign cur_gain = gain_vld_ff[ch_ff] ? gain_rd_ff : UNITY_Q15;
   assign cur_targ = lvl_vld_ff[ch_ff] ? targ_rd_ff : UNITY_Q15;
   assign cur_tick = lvl_vld_ff[ch_ff] ? tick_rd_ff : '0;
   assign run      = (cur_tick > elapsed_ff);

   // Fade step magnitude times elapsed ticks
   assign diff_neg = (cur_targ < cur_gain);
   assign diff_mag = diff_neg ? (cur_gain - cur_targ) : (cur_targ - cur_gain);
   assign prod     = 31'(diff_mag) * 31'(elapsed_ff);

   // One restoring divider step
   assign div_part  = {rem_ff, dvd_ff[TICK_W-1]};
   assign div_take  = (div_part >= {1'b0, left_ff});
   assign div_trial = div_part - {1'b0, left_ff};

   // Write-back values after the divide
   assign wr_gain = neg_ff ? (cur_ff - {1'b0, quo_ff}) : (cur_ff + {1'b0, quo_ff});
   assign wr_tick = left_ff - elapsed_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_ADVANCE: state_in = (req_elapsed_ticks == '0) ? S_RESULT : S_ADV_RD;
                  OP_SET:     state_in = S_SET;
                  OP_READ:    state_in = S_RD_ADDR;
                  OP_RESTORE: state_in = S_RESULT;
                  default:    state_in = S_RESULT;
               endcase
            end
         end
         S_ADV_RD:  state_in = S_ADV_MUL;
         S_ADV_MUL: begin
            if (run) begin
               state_in = S_ADV_DIV;
            end else begin
               state_in = last_ch ? S_RESULT : S_ADV_RD;
            end
         end
         S_ADV_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_ADV_WR;
            end
         end
         S_ADV_WR:  state_in = last_ch ? S_RESULT : S_ADV_RD;
         S_SET:     state_in = last_ch ? S_RESULT : S_SET;
         S_RD_ADDR: state_in = S_RD_DATA;
         S_RD_DATA: state_in = S_RESULT;
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      accept  = 1'b0;
      clr_all = 1'b0;
      gain_we = 1'b0;
      tick_we = 1'b0;
      targ_we = 1'b0;
      gain_wd = cur_targ;
      tick_wd = '0;
      rd_addr = ch_ff;
      ld_rsp  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            accept  = req_valid;
            clr_all = req_valid && (req_op == OP_RESTORE);
         end
         S_ADV_MUL: begin
            // snap to target once the fade is due
            if (!run) begin
               gain_we = 1'b1;
               gain_wd = cur_targ;
               tick_we = lvl_vld_ff[ch_ff];
               tick_wd = '0;
            end
         end
         S_ADV_WR: begin
            gain_we = 1'b1;
            gain_wd = wr_gain;
            tick_we = 1'b1;
            tick_wd = wr_tick;
         end
         S_SET: begin
            targ_we = mask_ff[ch_ff];
            tick_we = mask_ff[ch_ff];
            tick_wd = len_ff;
         end
         S_RD_ADDR: rd_addr = idx_ff;
         S_RESULT:  ld_rsp  = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      ch_in       = ch_ff;
      step_in     = step_ff;
      mask_in     = mask_ff;
      targ_in     = targ_ff;
      len_in      = len_ff;
      elapsed_in  = elapsed_ff;
      idx_in      = idx_ff;
      idx_ok_in   = idx_ok_ff;
      cur_in      = cur_ff;
      left_in     = left_ff;
      neg_in      = neg_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      quo_in      = quo_ff;
      res_gain_in = res_gain_ff;

      // latch the request word
      if (accept) begin
         ch_in       = '0;
         mask_in     = req_channel_mask[NUM_CHANNELS-1:0];
         targ_in     = tgt_clamp;
         len_in      = len_clamp;
         elapsed_in  = req_elapsed_ticks;
         idx_in      = req_channel_index[CH_W-1:0];
         idx_ok_in   = ({1'b0, req_channel_index} < (IDX_W + 1)'(NUM_CHANNELS));
         res_gain_in = '0;
      end

      // load the divider from the product
      if (state_ff == S_ADV_MUL) begin
         cur_in  = cur_gain;
         left_in = cur_tick;
         neg_in  = diff_neg;
         rem_in  = prod[2*TICK_W-1:TICK_W];
         dvd_in  = prod[TICK_W-1:0];
         quo_in  = '0;
         step_in = '0;
         if (!run) begin
            ch_in = ch_ff + 1'b1;
         end
      end

      // shift in one quotient bit
      if (state_ff == S_ADV_DIV) begin
         rem_in  = div_take ? div_trial[TICK_W-1:0] : div_part[TICK_W-1:0];
         dvd_in  = {dvd_ff[TICK_W-2:0], 1'b0};
         quo_in  = {quo_ff[TICK_W-2:0], div_take};
         step_in = step_ff + 1'b1;
      end

      // advance the channel pointer
      if ((state_ff == S_ADV_WR) || (state_ff == S_SET)) begin
         ch_in = ch_ff + 1'b1;
      end

      // capture the read gain
      if (state_ff == S_RD_DATA) begin
         if (idx_ok_ff) begin
            res_gain_in = gain_vld_ff[idx_ff] ? gain_rd_ff : UNITY_Q15;
         end else begin
            res_gain_in = '0;
         end
      end
   end

   // Valid bits
   always_comb begin
      gain_vld_in = gain_vld_ff;
      lvl_vld_in  = lvl_vld_ff;
      if (clr_all) begin
         gain_vld_in = '0;
         lvl_vld_in  = '0;
      end else begin
         if (gain_we) begin
            gain_vld_in[ch_ff] = 1'b1;
         end
         if (targ_we) begin
            lvl_vld_in[ch_ff] = 1'b1;
         end
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_gain_in  = rsp_gain_ff;
      if (ld_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_gain_in  = res_gain_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         step_ff      <= '0;
         gain_vld_ff  <= '0;
         lvl_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         step_ff      <= step_in;
         gain_vld_ff  <= gain_vld_in;
         lvl_vld_ff   <= lvl_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      targ_ff     <= targ_in;
      len_ff      <= len_in;
      elapsed_ff  <= elapsed_in;
      idx_ff      <= idx_in;
      idx_ok_ff   <= idx_ok_in;
      cur_ff      <= cur_in;
      left_ff     <= left_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      res_gain_ff <= res_gain_in;
      rsp_gain_ff <= rsp_gain_in;
   end

   // Channel memories: one write, one registered read
   always_ff @(posedge clock) begin
      if (gain_we) begin
         gain_mem[ch_ff] <= gain_wd;
      end
      if (targ_we) begin
         targ_mem[ch_ff] <= targ_ff;
      end
      if (tick_we) begin
         tick_mem[ch_ff] <= tick_wd;
      end
      gain_rd_ff <= gain_mem[rd_addr];
      targ_rd_ff <= targ_mem[rd_addr];
      tick_rd_ff <= tick_mem[rd_addr];
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_gain_out = rsp_gain_ff;
   assign rsp_done_res = 1'b1;

   // Checks
   `GFB_ASSERT_SAME(a_rem_below_divisor, clock, reset, (state_ff == S_ADV_DIV),
      (rem_ff < left_ff), "divider remainder not below divisor")
   `GFB_ASSERT_NEXT(a_div_length, clock, reset,
      ((state_ff == S_ADV_DIV) && (step_ff == STEP_W'(DIV_STEPS - 1))),
      (state_ff == S_ADV_WR), "divider did not finish after its last step")
   `GFB_ASSERT_SAME(a_gain_in_range, clock, reset, (state_ff == S_ADV_WR),
      (wr_gain <= UNITY_Q15), "faded gain above unity")
   `GFB_ASSERT_NEXT(a_result_loaded, clock, reset, ld_rsp,
      (rsp_valid_ff && (state_ff == S_IDLE)), "result word not loaded")

endmodule
